// File: design/iara_pkg.sv
package iara_pkg;

   localparam int Rules = 16;
   localparam int Classes = 8;
   localparam int RuleIdxW = $clog2(Rules);
   localparam int ClassIdxW = $clog2(Classes);
   localparam int QueueDepth = 2;

   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StFull    = 2'd1;
   localparam logic [1:0] StNoMatch = 2'd2;
   localparam logic [1:0] StNoClass = 2'd3;

   localparam logic [15:0] Unlimited = 16'hffff;
   localparam logic [23:0] AllHours  = 24'hffffff;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_WRULE  = 3'd1,
      OP_WCLASS = 3'd2,
      OP_CHECK  = 3'd3,
      OP_COUNT  = 3'd4,
      OP_REL    = 3'd5
   } opcode_type;

   // one classified request as it travels from front to back
   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  slot;
      logic [31:0] ip_addr;
      logic [31:0] ip_mask;
      logic [16:0] port;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [23:0] hour_bits;
      logic [7:0]  day_mask;
      logic [2:0]  class_ref;
      logic [15:0] cls_ident;
      logic [15:0] user_limit;
      logic        bypass;   // check with enforcement off
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] cls_ident;
      logic [3:0]  slot;
      logic [15:0] usage;
   } result_type;

endpackage

// File: design/ip_access_rule_admission.sv
// First-match IPv4 admission block with per-class connection limits.
// Requests enter on req_* (valid/stall); one result per request leaves
// on rsp_* (valid/stall). csr_write/csr_data set the enforce bit, to be
// written only while the block is idle.
// A front stage tags the request and pushes it into a two-entry queue;
// the back end executes one request at a time.
// Clear, table writes, unused codes and checks with enforcement off go
// straight from IDLE to DONE, with no scan.
// A check or count scans one rule per cycle; a release scans one class
// slot per cycle.
// A request leaves the queue only after the previous result is taken, so
// the back end never starts a request before the last one is through.
// Reset clears all valid bits, usage counters and the enforce bit; the
// block is ready on the first cycle after reset.
// A stalled result holds on rsp_*; the queue keeps taking requests until
// full, then req_stall rises.
module ip_access_rule_admission (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_ip_addr,
   input  logic [31:0] req_ip_mask,
   input  logic [16:0] req_port,
   input  logic [4:0]  req_hour,
   input  logic [2:0]  req_weekday,
   input  logic [23:0] req_hour_mask,
   input  logic [7:0]  req_day_mask,
   input  logic [2:0]  req_class_ref,
   input  logic [15:0] req_class_id,
   input  logic [15:0] req_max_usage,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_class_id,
   output logic [3:0]  rsp_result_slot,
   output logic [15:0] rsp_usage_count
);

   iara_pkg::request_type in_req, front_req, q_data;
   iara_pkg::result_type res;
   logic full, empty, pop, take;

   assign take = req_valid && !full;
   assign req_stall = full;

   always_comb begin
      in_req = '0;
      in_req.opcode = req_opcode;
      in_req.slot = req_slot;
      in_req.ip_addr = req_ip_addr;
      in_req.ip_mask = req_ip_mask;
      in_req.port = req_port;
      in_req.hour = req_hour;
      in_req.weekday = req_weekday;
      in_req.hour_bits = req_hour_mask;
      in_req.day_mask = req_day_mask;
      in_req.class_ref = req_class_ref;
      in_req.cls_ident = req_class_id;
      in_req.user_limit = req_max_usage;
   end

   iara_front u_front (
      .clock, .reset, .csr_write, .csr_data,
      .in_req, .out_req(front_req)
   );

   iara_queue u_queue (
      .clock, .reset, .push(take), .push_data(front_req), .full,
      .pop, .empty, .pop_data(q_data)
   );

   iara_back u_back (
      .clock, .reset, .q_empty(empty), .q_data, .q_pop(pop),
      .res_valid(rsp_valid), .res, .res_stall(rsp_stall)
   );

   assign rsp_status = res.status;
   assign rsp_result_class_id = res.cls_ident;
   assign rsp_result_slot = res.slot;
   assign rsp_usage_count = res.usage;

endmodule

// File: design/iara_queue.sv
module iara_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  iara_pkg::request_type  push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output iara_pkg::request_type  pop_data
);

   localparam int AW = $clog2(iara_pkg::QueueDepth);

   iara_pkg::request_type mem_ff [iara_pkg::QueueDepth];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;

   assign full = (cnt_ff == (AW+1)'(iara_pkg::QueueDepth));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// File: design/iara_front.sv
module iara_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic                  csr_data,
   input  iara_pkg::request_type in_req,
   output iara_pkg::request_type out_req
);

   logic enable_ff;

   // checks with enforcement off skip the table entirely
   always_comb begin
      out_req = in_req;
      out_req.bypass = (in_req.opcode == iara_pkg::OP_CHECK) && !enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) enable_ff <= 1'b0;
      else if (csr_write) enable_ff <= csr_data;
   end

endmodule

// File: design/iara_back.sv
module iara_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  iara_pkg::request_type q_data,
   output logic                  q_pop,
   output logic                  res_valid,
   output iara_pkg::result_type  res,
   input  logic                  res_stall
);

   typedef enum logic [1:0] {IDLE, SCAN, CLASS, DONE} state_type;

   state_type state_ff;
   iara_pkg::request_type req_ff;
   logic [iara_pkg::RuleIdxW:0] idx_ff;
   iara_pkg::result_type res_ff;
   logic valid_ff;

   logic [iara_pkg::Rules-1:0]  rv_ff;
   logic [31:0] ra_ff [iara_pkg::Rules];
   logic [31:0] rm_ff [iara_pkg::Rules];
   logic [16:0] rp_ff [iara_pkg::Rules];
   logic [23:0] rh_ff [iara_pkg::Rules];
   logic [7:0]  rd_ff [iara_pkg::Rules];
   logic [2:0]  rc_ff [iara_pkg::Rules];
   logic [iara_pkg::Classes-1:0] cv_ff;
   logic [15:0] ci_ff [iara_pkg::Classes];
   logic [15:0] cl_ff [iara_pkg::Classes];
   logic [15:0] cu_ff [iara_pkg::Classes];
   logic [2:0]  hit_class_ff;

   logic [iara_pkg::RuleIdxW-1:0]  ri;
   logic [iara_pkg::ClassIdxW-1:0] ci;
   logic [iara_pkg::ClassIdxW-1:0] hc;
   logic rule_hit;
   logic [23:0] hm;
   logic [15:0] cur;

   assign ri = idx_ff[iara_pkg::RuleIdxW-1:0];
   assign ci = idx_ff[iara_pkg::ClassIdxW-1:0];
   assign hc = hit_class_ff[iara_pkg::ClassIdxW-1:0];
   assign cur = cu_ff[hc];

   always_comb begin
      hm = (rh_ff[ri] == '0) ? iara_pkg::AllHours : rh_ff[ri];
      rule_hit = rv_ff[ri]
         && (rp_ff[ri][16] || rp_ff[ri] == req_ff.port)
         && (((ra_ff[ri] ^ req_ff.ip_addr) & rm_ff[ri]) == '0)
         && (rd_ff[ri][7] || (req_ff.hour < 5'd24 && hm[req_ff.hour]
             && req_ff.weekday < 3'd7 && rd_ff[ri][req_ff.weekday]));
   end

   assign q_pop = (state_ff == IDLE) && !q_empty && !valid_ff;
   assign res_valid = valid_ff;
   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
         rv_ff <= '0;
         cv_ff <= '0;
         for (int k = 0; k < iara_pkg::Classes; k++) cu_ff[k] <= '0;
      end else begin
         if (state_ff == DONE) valid_ff <= 1'b1;
         else if (!res_stall) valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (q_pop) begin
                  req_ff <= q_data;
                  idx_ff <= '0;
                  res_ff.status <= (q_data.opcode == iara_pkg::OP_REL) ?
                     iara_pkg::StNoClass : iara_pkg::StOk;
                  res_ff.cls_ident <= (q_data.opcode == iara_pkg::OP_WCLASS
                     && 32'(q_data.slot) < iara_pkg::Classes) ? q_data.cls_ident : '0;
                  res_ff.slot <= '0;
                  res_ff.usage <= '0;
                  if (q_data.opcode == iara_pkg::OP_REL) begin
                     state_ff <= CLASS;
                  end else if ((q_data.opcode == iara_pkg::OP_CHECK
                                || q_data.opcode == iara_pkg::OP_COUNT) && !q_data.bypass) begin
                     state_ff <= SCAN;
                  end else begin
                     state_ff <= DONE;
                  end
                  unique case (q_data.opcode)
                     iara_pkg::OP_CLEAR: begin
                        rv_ff <= '0;
                        cv_ff <= '0;
                        for (int k = 0; k < iara_pkg::Classes; k++) cu_ff[k] <= '0;
                     end
                     iara_pkg::OP_WRULE: begin
                        if (32'(q_data.slot) < iara_pkg::Rules) begin
                           rv_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= 1'b1;
                           ra_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= q_data.ip_addr;
                           rm_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= q_data.ip_mask;
                           rp_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= q_data.port;
                           rh_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= q_data.hour_bits;
                           rd_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= q_data.day_mask;
                           rc_ff[q_data.slot[iara_pkg::RuleIdxW-1:0]] <= q_data.class_ref;
                        end
                     end
                     iara_pkg::OP_WCLASS: begin
                        if (32'(q_data.slot) < iara_pkg::Classes) begin
                           cv_ff[q_data.slot[iara_pkg::ClassIdxW-1:0]] <= 1'b1;
                           ci_ff[q_data.slot[iara_pkg::ClassIdxW-1:0]] <= q_data.cls_ident;
                           cl_ff[q_data.slot[iara_pkg::ClassIdxW-1:0]] <= q_data.user_limit;
                           cu_ff[q_data.slot[iara_pkg::ClassIdxW-1:0]] <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            SCAN: begin
               // one rule per cycle, first hit wins
               if (idx_ff == (iara_pkg::RuleIdxW+1)'(iara_pkg::Rules)) begin
                  res_ff.status <= iara_pkg::StNoMatch;
                  state_ff <= DONE;
               end else if (rule_hit) begin
                  res_ff.slot <= 4'(ri);
                  hit_class_ff <= rc_ff[ri];
                  state_ff <= CLASS;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            CLASS: begin
               if (req_ff.opcode == iara_pkg::OP_REL) begin
                  // lowest valid slot with that id, one slot per cycle
                  if (idx_ff == (iara_pkg::RuleIdxW+1)'(iara_pkg::Classes)) begin
                     state_ff <= DONE;
                  end else if (cv_ff[ci] && ci_ff[ci] == req_ff.cls_ident) begin
                     if (cu_ff[ci] != '0) cu_ff[ci] <= cu_ff[ci] - 1'b1;
                     res_ff.status <= iara_pkg::StOk;
                     res_ff.cls_ident <= req_ff.cls_ident;
                     res_ff.usage <= (cu_ff[ci] != '0) ? cu_ff[ci] - 1'b1 : '0;
                     state_ff <= DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  state_ff <= DONE;
                  if (32'(hit_class_ff) >= iara_pkg::Classes || !cv_ff[hc]) begin
                     res_ff.status <= iara_pkg::StNoClass;
                  end else begin
                     res_ff.cls_ident <= ci_ff[hc];
                     if (req_ff.opcode == iara_pkg::OP_CHECK
                         && cl_ff[hc] != iara_pkg::Unlimited && cur >= cl_ff[hc]) begin
                        res_ff.status <= iara_pkg::StFull;
                        res_ff.usage <= cur;
                     end else begin
                        if (cur != 16'hffff) cu_ff[hc] <= cur + 1'b1;
                        res_ff.usage <= (cur != 16'hffff) ? cur + 1'b1 : cur;
                     end
                  end
               end
            end
            DONE: begin
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// File: design/iara_checker.sv
module iara_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_result_slot
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped under stall");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity after reset");

   a_nomatch_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == iara_pkg::StNoMatch |-> rsp_result_slot == '0)
      else $error("slot set without a match");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request withdrawn under stall");

endmodule

bind ip_access_rule_admission iara_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_result_slot
);
